/* rtl/core/twhq_pkg.sv */
// Shared constants, codes and types of the timed work heap queue.
package twhq_pkg;

    localparam int SLOT_DEPTH = 16;
    localparam int ADDR_W     = $clog2(SLOT_DEPTH);
    localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int LIM_W      = CNT_W + CFG_W;
    localparam int ID_W       = 8;
    localparam int TIME_W     = 32;
    localparam int OP_W       = 5;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    localparam logic [1:0] CMD_SCHED  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_LATE  = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH     = 5'd1;
    localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd2;
    localparam logic [OP_W-1:0] OP_RD_IDX    = 5'd3;
    localparam logic [OP_W-1:0] OP_SCAN_NEXT = 5'd4;
    localparam logic [OP_W-1:0] OP_RD_LAST   = 5'd5;
    localparam logic [OP_W-1:0] OP_MOVE_LAST = 5'd6;
    localparam logic [OP_W-1:0] OP_DEC       = 5'd7;
    localparam logic [OP_W-1:0] OP_RB_INIT   = 5'd8;
    localparam logic [OP_W-1:0] OP_SIFT_GO   = 5'd9;
    localparam logic [OP_W-1:0] OP_CAP_I     = 5'd10;
    localparam logic [OP_W-1:0] OP_RD_L      = 5'd11;
    localparam logic [OP_W-1:0] OP_RD_R      = 5'd12;
    localparam logic [OP_W-1:0] OP_CMP       = 5'd13;
    localparam logic [OP_W-1:0] OP_SW1       = 5'd14;
    localparam logic [OP_W-1:0] OP_SW2       = 5'd15;
    localparam logic [OP_W-1:0] OP_K_DEC     = 5'd16;
    localparam logic [OP_W-1:0] OP_RD_HEAD   = 5'd17;
    localparam logic [OP_W-1:0] OP_HEAD_LATE = 5'd18;
    localparam logic [OP_W-1:0] OP_HEAD_CAP  = 5'd19;
    localparam logic [OP_W-1:0] OP_APPEND    = 5'd20;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] per;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            set_st;
        logic [1:0]      st;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       idx_lt_n;
        logic       id_match;
        logic       n_gt1;
        logic       l_lt_n;
        logic       r_lt_n;
        logic       best_is_i;
        logic       k_zero;
        logic       full;
        logic       head_late;
        logic       per_nz;
    } dp_stat_t;

endpackage

/* rtl/core/timed_work_heap_queue_top.sv */
// Top level of the timed work heap queue: ports, slot register, result register.
// Work per request: an empty pop or an unknown command goes straight to the result, and a pop
//   whose head is not due reads only the head; otherwise the id search examines the entries
//   in turn, and each rebuild sifts every parent down, with a swap at each level it sinks.
// Throughput: one request in work at a time; the next is taken the cycle after its result loads.
// Reset: control, count and result valid clear; the slot register returns to 16; store not cleared.
module timed_work_heap_queue_top import twhq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // item_id[7:0], due_time[39:8], period[71:40], now_time[103:72]
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // out_id[7:0], out_time[39:8], entry_count[43:40], zero[47:44]
    output logic [1:0]   m_tuser,   // status[1:0]
    // slot register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data
);

    logic [CFG_W-1:0]  slots_reg;
    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    entry_t            in_entry;
    logic              out_free;
    logic              out_load;
    logic [1:0]        res_status;
    logic [ID_W-1:0]   res_id;
    logic [TIME_W-1:0] res_time;
    logic [CNT_W-1:0]  res_count;

    // Slot register is writable out of reset; the user must write it only while idle, the block does not enforce it.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= SLOTS_RESET;
        end else if (cfg_valid) begin
            slots_reg <= cfg_data;
        end
    end

    assign in_entry.id  = s_tdata[7:0];
    assign in_entry.due = s_tdata[39:8];
    assign in_entry.per = s_tdata[71:40];

    twhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    twhq_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dp_cmd),
        .in_cmd     (s_tuser),
        .in_entry   (in_entry),
        .in_now     (s_tdata[103:72]),
        .slots      (slots_reg),
        .stat       (dp_stat),
        .res_status (res_status),
        .res_id     (res_id),
        .res_time   (res_time),
        .res_count  (res_count)
    );

    // Result register: free when empty or being taken this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Count never exceeds fifteen, so four bits carry it.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'b0, res_count[3:0], res_time, res_id};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/core/twhq_dpath.sv */
// Datapath: entry store, count, scan and sift registers, result registers.
module twhq_dpath import twhq_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    input  logic [1:0]              in_cmd,
    input  entry_t                  in_entry,
    input  logic [TIME_W-1:0]       in_now,
    input  logic [CFG_W-1:0]        slots,
    output dp_stat_t                stat,
    output logic [1:0]              res_status,
    output logic [ID_W-1:0]         res_id,
    output logic [TIME_W-1:0]       res_time,
    output logic [CNT_W-1:0]        res_count
);

    entry_t              mem [SLOT_DEPTH];
    entry_t              rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    entry_t              work_reg;
    entry_t              hold_reg;
    entry_t              best_e_reg;
    logic [TIME_W-1:0]   best_t_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [1:0]          cmd_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [ADDR_W-1:0]   i_reg;
    logic [ADDR_W-1:0]   best_reg;
    logic [1:0]          st_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [TIME_W-1:0]   res_time_reg;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic [ADDR_W:0]     l_idx;
    logic [ADDR_W:0]     r_idx;
    logic [LIM_W-1:0]    slot_clamp;
    logic [LIM_W-1:0]    limit;
    logic [CNT_W-1:0]    k_m1;
    logic [CNT_W-1:0]    n_m1;

    assign l_idx = {i_reg, 1'b1};
    assign r_idx = l_idx + 1'b1;
    assign k_m1  = k_reg - 1'b1;
    assign n_m1  = n_reg - 1'b1;

    // Slot limit: zero acts as one, anything above the depth as the depth.
    always_comb begin
        if (slots == '0) begin
            slot_clamp = LIM_W'(1);
        end else if (LIM_W'(slots) > LIM_W'(SLOT_DEPTH)) begin
            slot_clamp = LIM_W'(SLOT_DEPTH);
        end else begin
            slot_clamp = LIM_W'(slots);
        end
        limit = slot_clamp - LIM_W'(1);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = work_reg;
        case (cmd.op)
            OP_RD_IDX: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[ADDR_W-1:0];
            end
            OP_RD_LAST: begin
                rd_en   = 1'b1;
                rd_addr = n_m1[ADDR_W-1:0];
            end
            OP_SIFT_GO: begin
                rd_en   = 1'b1;
                rd_addr = k_m1[ADDR_W-1:0];
            end
            OP_RD_L: begin
                rd_en   = 1'b1;
                rd_addr = l_idx[ADDR_W-1:0];
            end
            OP_RD_R: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[ADDR_W-1:0];
            end
            OP_RD_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_MOVE_LAST: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = rd_data_reg;
            end
            OP_SW1: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = best_e_reg;
            end
            OP_SW2: begin
                wr_en   = 1'b1;
                wr_addr = best_reg;
                wr_data = hold_reg;
            end
            OP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = n_reg[ADDR_W-1:0];
                wr_data = work_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else begin
            case (cmd.op)
                OP_MOVE_LAST, OP_DEC: n_reg <= n_m1;
                OP_APPEND:            n_reg <= n_reg + 1'b1;
                default:              n_reg <= n_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_st) begin
            st_reg <= cmd.st;
        end
        case (cmd.op)
            OP_LATCH: begin
                work_reg     <= in_entry;
                now_reg      <= in_now;
                cmd_reg      <= in_cmd;
                res_id_reg   <= '0;
                res_time_reg <= '0;
            end
            OP_SCAN_INIT: idx_reg <= '0;
            OP_SCAN_NEXT: idx_reg <= idx_reg + 1'b1;
            OP_RB_INIT:   k_reg   <= n_reg >> 1;
            OP_K_DEC:     k_reg   <= k_m1;
            OP_SIFT_GO:   i_reg   <= k_m1[ADDR_W-1:0];
            OP_CAP_I: begin
                hold_reg   <= rd_data_reg;
                best_reg   <= i_reg;
                best_t_reg <= rd_data_reg.due;
            end
            OP_CMP: begin
                if (rd_data_reg.due < best_t_reg) begin
                    best_reg   <= rd_addr_reg;
                    best_t_reg <= rd_data_reg.due;
                    best_e_reg <= rd_data_reg;
                end
            end
            OP_SW2: begin
                // The moved entry is the parent of the next level.
                i_reg      <= best_reg;
                best_t_reg <= hold_reg.due;
            end
            OP_HEAD_LATE: res_time_reg <= rd_data_reg.due;
            OP_HEAD_CAP: begin
                res_id_reg   <= rd_data_reg.id;
                res_time_reg <= rd_data_reg.due;
                work_reg.id  <= rd_data_reg.id;
                work_reg.due <= now_reg + rd_data_reg.per;
                work_reg.per <= rd_data_reg.per;
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign stat.cmd       = cmd_reg;
    assign stat.cnt_zero  = (n_reg == '0);
    assign stat.idx_lt_n  = (idx_reg < n_reg);
    assign stat.id_match  = (rd_data_reg.id == work_reg.id);
    assign stat.n_gt1     = (n_reg > CNT_W'(1));
    assign stat.l_lt_n    = (LIM_W'(l_idx) < LIM_W'(n_reg));
    assign stat.r_lt_n    = (LIM_W'(r_idx) < LIM_W'(n_reg));
    assign stat.best_is_i = (best_reg == i_reg);
    assign stat.k_zero    = (k_reg == '0);
    assign stat.full      = (LIM_W'(n_reg) >= limit);
    assign stat.head_late = (rd_data_reg.due > now_reg);
    assign stat.per_nz    = (work_reg.per != '0);

    assign res_status = st_reg;
    assign res_id     = res_id_reg;
    assign res_time   = res_time_reg;
    assign res_count  = n_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LIM_W'(n_reg) < LIM_W'(SLOT_DEPTH))
        else $error("entry count beyond slot depth");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_APPEND |-> !stat.full)
        else $error("append into a full queue");
    a_swap_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_SW1 |-> best_reg != i_reg)
        else $error("swap without a smaller child");
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DEC || cmd.op == OP_MOVE_LAST) |-> n_reg != '0)
        else $error("removal from an empty queue");

endmodule

/* rtl/core/twhq_ctrl.sv */
// Controller: sequences id search, removal, append, heap rebuild and result.
module twhq_ctrl import twhq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output logic      out_load,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_HEAD_W  = 5'd2;
    localparam logic [4:0] S_SCAN0   = 5'd3;
    localparam logic [4:0] S_SCAN    = 5'd4;
    localparam logic [4:0] S_SCAN_W  = 5'd5;
    localparam logic [4:0] S_MOVE    = 5'd6;
    localparam logic [4:0] S_RB0     = 5'd7;
    localparam logic [4:0] S_RB_K    = 5'd8;
    localparam logic [4:0] S_SIFT_I  = 5'd9;
    localparam logic [4:0] S_SIFT_L  = 5'd10;
    localparam logic [4:0] S_SIFT_LW = 5'd11;
    localparam logic [4:0] S_SIFT_R  = 5'd12;
    localparam logic [4:0] S_SIFT_RW = 5'd13;
    localparam logic [4:0] S_SIFT_D  = 5'd14;
    localparam logic [4:0] S_SW2     = 5'd15;
    localparam logic [4:0] S_POST_RM = 5'd16;
    localparam logic [4:0] S_INS     = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       found_reg, found_next;
    logic       ins_reg, ins_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            ins_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            ins_reg   <= ins_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        ins_next   = ins_reg;
        cmd        = '{op: OP_NONE, set_st: 1'b0, st: ST_OK};
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd        = '{op: OP_LATCH, set_st: 1'b1, st: ST_EMPTY};
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    CMD_SCHED, CMD_CANCEL: begin
                        state_next = S_SCAN0;
                    end
                    CMD_POP: begin
                        if (stat.cnt_zero) begin
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = OP_RD_HEAD;
                            state_next = S_HEAD_W;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_HEAD_W: begin
                if (stat.head_late) begin
                    cmd        = '{op: OP_HEAD_LATE, set_st: 1'b1, st: ST_LATE};
                    state_next = S_DONE;
                end else begin
                    cmd        = '{op: OP_HEAD_CAP, set_st: 1'b1, st: ST_OK};
                    state_next = S_SCAN0;
                end
            end
            S_SCAN0: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.idx_lt_n) begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_SCAN_W;
                end else begin
                    state_next = S_POST_RM;
                end
            end
            S_SCAN_W: begin
                if (stat.id_match) begin
                    found_next = 1'b1;
                    if (stat.n_gt1) begin
                        cmd.op     = OP_RD_LAST;
                        state_next = S_MOVE;
                    end else begin
                        cmd.op     = OP_DEC;
                        state_next = S_RB0;
                    end
                end else begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_MOVE: begin
                cmd.op     = OP_MOVE_LAST;
                state_next = S_RB0;
            end
            S_RB0: begin
                cmd.op     = OP_RB_INIT;
                state_next = S_RB_K;
            end
            S_RB_K: begin
                if (stat.k_zero) begin
                    state_next = ins_reg ? S_DONE : S_POST_RM;
                end else begin
                    cmd.op     = OP_SIFT_GO;
                    state_next = S_SIFT_I;
                end
            end
            S_SIFT_I: begin
                cmd.op     = OP_CAP_I;
                state_next = S_SIFT_L;
            end
            S_SIFT_L: begin
                if (stat.l_lt_n) begin
                    cmd.op     = OP_RD_L;
                    state_next = S_SIFT_LW;
                end else begin
                    state_next = S_SIFT_R;
                end
            end
            S_SIFT_LW: begin
                cmd.op     = OP_CMP;
                state_next = S_SIFT_R;
            end
            S_SIFT_R: begin
                if (stat.r_lt_n) begin
                    cmd.op     = OP_RD_R;
                    state_next = S_SIFT_RW;
                end else begin
                    state_next = S_SIFT_D;
                end
            end
            S_SIFT_RW: begin
                cmd.op     = OP_CMP;
                state_next = S_SIFT_D;
            end
            S_SIFT_D: begin
                if (stat.best_is_i) begin
                    cmd.op     = OP_K_DEC;
                    state_next = S_RB_K;
                end else begin
                    cmd.op     = OP_SW1;
                    state_next = S_SW2;
                end
            end
            S_SW2: begin
                cmd.op     = OP_SW2;
                state_next = S_SIFT_L;
            end
            S_POST_RM: begin
                case (stat.cmd)
                    CMD_SCHED: begin
                        state_next = S_INS;
                    end
                    CMD_CANCEL: begin
                        cmd.set_st = 1'b1;
                        cmd.st     = found_reg ? ST_OK : ST_EMPTY;
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = stat.per_nz ? S_INS : S_DONE;
                    end
                endcase
            end
            S_INS: begin
                if (stat.full) begin
                    // A periodic head with no room is dropped silently.
                    cmd.set_st = (stat.cmd == CMD_SCHED);
                    cmd.st     = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd        = '{op: OP_APPEND, set_st: 1'b1, st: ST_OK};
                    ins_next   = 1'b1;
                    state_next = S_RB0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a waiting result");
    a_accept_then_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> state_reg == S_DISP)
        else $error("accepted request not dispatched");

endmodule
